// File: rtl/text_console_cursor_and_scroll_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text console core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_AND_SCROLL_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_AND_SCROLL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define TCCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tccs same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define TCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tccs next-cycle check failed");
`else
`define TCCS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/tccs_pkg.sv
// ---------------------------------------------------------------------------
// Text console core package
// Command codes, internal operation classes and the words that move
// between the front end, the queues and the execution engine.
// ---------------------------------------------------------------------------
package tccs_pkg;

  // Host command codes on in_cmd.
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Control characters interpreted by a put.
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  // Register selects on paddr[2].
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;
  localparam logic REG_SCROLL_FILL    = 1'b1;

  localparam logic [7:0]  TEXT_ATTRIBUTE_RESET = 8'd7;
  localparam logic [15:0] SCROLL_FILL_RESET    = 16'd1824;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_SCROLL,
    OP_SCROLL_ALL,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  char_code;
    logic [7:0]  row_count;
    logic [15:0] fill_entry;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/tccs_fifo.sv
// ---------------------------------------------------------------------------
// Small synchronous FIFO
// Register-based queue used between the front end and the engine and as
// the result buffer.
// ---------------------------------------------------------------------------
module tccs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/tccs_front.sv
// ---------------------------------------------------------------------------
// Text console front end
// Accepts host words and sorts each into an internal operation class.
// ---------------------------------------------------------------------------
module tccs_front #(
  parameter int ROWS = 25
) (
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_char_code,
  input  logic [7:0]         in_row_count,
  input  logic [15:0]        in_fill_entry,
  input  logic [10:0]        in_cell_index,
  input  logic               queue_full,
  input  logic               engine_busy,
  output logic               queue_wr,
  output tccs_pkg::cmd_t     queue_word
);

  tccs_pkg::op_t op;

  // The engine's power-up clearing pass holds the input closed.
  assign full     = queue_full || engine_busy;
  assign queue_wr = push && !full;

  always_comb begin
    case (in_cmd)
      tccs_pkg::CMD_PUT: begin
        case (in_char_code)
          tccs_pkg::CH_NEWLINE:   op = tccs_pkg::OP_NEWLINE;
          tccs_pkg::CH_RETURN:    op = tccs_pkg::OP_RETURN;
          tccs_pkg::CH_BACKSPACE: op = tccs_pkg::OP_BACKSPACE;
          default:                op = tccs_pkg::OP_PRINT;
        endcase
      end
      tccs_pkg::CMD_SCROLL: begin
        op = (in_row_count >= 8'(ROWS)) ? tccs_pkg::OP_SCROLL_ALL : tccs_pkg::OP_SCROLL;
      end
      tccs_pkg::CMD_CLEAR: op = tccs_pkg::OP_CLEAR;
      tccs_pkg::CMD_READ:  op = tccs_pkg::OP_READ;
      default:             op = tccs_pkg::OP_READ;
    endcase
  end

  always_comb begin
    queue_word.op         = op;
    queue_word.char_code  = in_char_code;
    queue_word.row_count  = in_row_count;
    queue_word.fill_entry = in_fill_entry;
    queue_word.cell_index = in_cell_index;
  end

endmodule

// File: rtl/tccs_engine.sv
// ---------------------------------------------------------------------------
// Text console execution engine
// Holds the cursor and the cell store and carries out one operation at a
// time: single-cell writes, row copies for scrolling and fill sweeps.
// ---------------------------------------------------------------------------
`include "text_console_cursor_and_scroll_core_defines.svh"

module tccs_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        text_attribute,
  input  logic [15:0]       scroll_fill,
  input  logic              cmd_empty,
  input  tccs_pkg::cmd_t    cmd_word,
  output logic              cmd_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output tccs_pkg::result_t res_word,
  output logic              busy
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int IDX_W  = (CNT_W > 11) ? CNT_W : 11;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  tccs_pkg::state_t state_r, state_nxt;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] src_r, src_nxt;
  logic [CNT_W-1:0] dst_r, dst_nxt;
  logic             pend_r, pend_nxt;
  logic [15:0]      fill_r, fill_nxt;
  logic             is_read_r, is_read_nxt;
  logic             rd_ok_r, rd_ok_nxt;

  logic [15:0]       store_r [CELLS];
  logic [15:0]       rdata_r;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;

  logic [CNT_W-1:0]  pos_c;
  logic [IDX_W-1:0]  idx_w;

  assign pos_c = CNT_W'(row_r * COLUMNS + col_r);
  assign idx_w = IDX_W'(cmd_word.cell_index);
  assign busy  = (state_r == tccs_pkg::ST_INIT);

  always_comb begin
    res_word.cursor_row = 5'(row_r);
    res_word.cursor_col = 7'(col_r);
    res_word.cursor_pos = 11'(pos_c);
    res_word.cell_data  = (is_read_r && rd_ok_r) ? rdata_r : 16'd0;
  end

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    pend_nxt    = 1'b0;
    fill_nxt    = fill_r;
    is_read_nxt = is_read_r;
    rd_ok_nxt   = rd_ok_r;
    cmd_pop     = 1'b0;
    res_valid   = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = dst_r[ADDR_W-1:0];
    raddr       = src_r[ADDR_W-1:0];
    wdata       = fill_r;

    case (state_r)
      tccs_pkg::ST_INIT: begin
        we    = 1'b1;
        wdata = 16'd0;
        if (dst_r == CNT_W'(CELLS - 1)) begin
          state_nxt = tccs_pkg::ST_IDLE;
        end else begin
          dst_nxt = dst_r + 1'b1;
        end
      end

      tccs_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop     = 1'b1;
          is_read_nxt = 1'b0;
          state_nxt   = tccs_pkg::ST_RESULT;
          case (cmd_word.op)
            tccs_pkg::OP_PRINT, tccs_pkg::OP_NEWLINE: begin
              if (cmd_word.op == tccs_pkg::OP_PRINT) begin
                we    = 1'b1;
                waddr = pos_c[ADDR_W-1:0];
                wdata = {text_attribute, cmd_word.char_code};
              end
              if (cmd_word.op == tccs_pkg::OP_PRINT && col_r != COL_W'(COLUMNS - 1)) begin
                col_nxt = col_r + 1'b1;
              end else begin
                col_nxt = '0;
                if (row_r == ROW_W'(ROWS - 1)) begin
                  // Past the last row: scroll up one row, cursor stays on it.
                  src_nxt   = CNT_W'(COLUMNS);
                  dst_nxt   = '0;
                  fill_nxt  = scroll_fill;
                  state_nxt = tccs_pkg::ST_COPY;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end
            end
            tccs_pkg::OP_RETURN: begin
              col_nxt = '0;
            end
            tccs_pkg::OP_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end
            end
            tccs_pkg::OP_SCROLL: begin
              if (cmd_word.row_count != 8'd0) begin
                if (8'(row_r) >= cmd_word.row_count) begin
                  row_nxt = ROW_W'(8'(row_r) - cmd_word.row_count);
                end else begin
                  row_nxt = '0;
                end
                src_nxt   = CNT_W'(cmd_word.row_count * COLUMNS);
                dst_nxt   = '0;
                fill_nxt  = cmd_word.fill_entry;
                state_nxt = tccs_pkg::ST_COPY;
              end
            end
            tccs_pkg::OP_SCROLL_ALL: begin
              row_nxt   = '0;
              dst_nxt   = '0;
              fill_nxt  = cmd_word.fill_entry;
              state_nxt = tccs_pkg::ST_FILL;
            end
            tccs_pkg::OP_CLEAR: begin
              dst_nxt   = '0;
              fill_nxt  = cmd_word.fill_entry;
              state_nxt = tccs_pkg::ST_FILL;
            end
            tccs_pkg::OP_READ: begin
              re          = 1'b1;
              raddr       = idx_w[ADDR_W-1:0];
              rd_ok_nxt   = (idx_w < IDX_W'(CELLS));
              is_read_nxt = 1'b1;
            end
            default: begin
              state_nxt = tccs_pkg::ST_RESULT;
            end
          endcase
        end
      end

      tccs_pkg::ST_COPY: begin
        // Each read feeds the write in the cycle after it.
        re    = (src_r != CNT_W'(CELLS));
        we    = pend_r;
        wdata = rdata_r;
        if (pend_r) begin
          dst_nxt = dst_r + 1'b1;
        end
        if (re) begin
          src_nxt  = src_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          state_nxt = tccs_pkg::ST_FILL;
        end
      end

      tccs_pkg::ST_FILL: begin
        we = 1'b1;
        if (dst_r == CNT_W'(CELLS - 1)) begin
          state_nxt = tccs_pkg::ST_RESULT;
        end else begin
          dst_nxt = dst_r + 1'b1;
        end
      end

      tccs_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = tccs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tccs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tccs_pkg::ST_INIT;
      row_r     <= '0;
      col_r     <= '0;
      src_r     <= '0;
      dst_r     <= '0;
      pend_r    <= 1'b0;
      is_read_r <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      pend_r    <= pend_nxt;
      is_read_r <= is_read_nxt;
      rd_ok_r   <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  `TCCS_ASSERT_NEXT(a_result_then_idle, clk, rst_n, res_valid && res_ready, state_r == tccs_pkg::ST_IDLE)
  `TCCS_ASSERT_SAME(a_copy_dst_below_src, clk, rst_n, state_r == tccs_pkg::ST_COPY && pend_r, dst_r < src_r)
  `TCCS_ASSERT_NEXT(a_init_runs_to_end, clk, rst_n, state_r == tccs_pkg::ST_INIT && dst_r != CNT_W'(CELLS - 1), state_r == tccs_pkg::ST_INIT)
  `TCCS_ASSERT_NEXT(a_cursor_moves_on_pop, clk, rst_n, !cmd_pop && state_r != tccs_pkg::ST_IDLE, $stable(col_r))

endmodule

// File: rtl/text_console_cursor_and_scroll_core.sv
// ---------------------------------------------------------------------------
// Text console cursor and scroll core
// Character-cell console engine with cursor tracking, scrolling, clearing
// and cell readback over a COLUMNS by ROWS store of 16-bit cells.
// ---------------------------------------------------------------------------
//
//   channel  handshake                      word
//   -------  -----------------------------  -----------------------------------
//   input    push / full                    in_cmd, in_char_code, in_row_count,
//                                           in_fill_entry, in_cell_index
//   result   empty / pop                    out_cursor_row, out_cursor_col,
//                                           out_cursor_pos, out_cell_data
//   config   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A return, backspace, read, zero-row scroll or a put that stays within the
// last row goes from idle straight to the result word. A put that passes
// the last row and a scroll by n rows (0 < n < ROWS) copy the kept rows up
// and then fill the rest, and a clear or a full-screen scroll fills the
// whole store. These sweeps are paced by the single write port of the cell
// store, which is swept one cell per cycle.
// After reset the store is cleared with full held high; configuration
// writes are still taken.
// Two-word queues on each side let input and result stall independently.
//
module text_console_cursor_and_scroll_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_row_count,
  input  logic [15:0] in_fill_entry,
  input  logic [10:0] in_cell_index,

  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic [10:0] out_cursor_pos,
  output logic [15:0] out_cell_data,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CMD_W = $bits(tccs_pkg::cmd_t);
  localparam int RES_W = $bits(tccs_pkg::result_t);

  // Configuration registers. The user must change them only while the core is
  // idle; the block does not enforce it. The engine reads them directly.
  logic [7:0]  text_attribute_r, text_attribute_nxt;
  logic [15:0] scroll_fill_r, scroll_fill_nxt;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    text_attribute_nxt = text_attribute_r;
    scroll_fill_nxt    = scroll_fill_r;
    if (cfg_write) begin
      case (paddr[2])
        tccs_pkg::REG_TEXT_ATTRIBUTE: text_attribute_nxt = pwdata[7:0];
        tccs_pkg::REG_SCROLL_FILL:    scroll_fill_nxt    = pwdata[15:0];
        default: begin
          text_attribute_nxt = text_attribute_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tccs_pkg::REG_TEXT_ATTRIBUTE: prdata = {24'd0, text_attribute_r};
      tccs_pkg::REG_SCROLL_FILL:    prdata = {16'd0, scroll_fill_r};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attribute_r <= tccs_pkg::TEXT_ATTRIBUTE_RESET;
      scroll_fill_r    <= tccs_pkg::SCROLL_FILL_RESET;
    end else begin
      text_attribute_r <= text_attribute_nxt;
      scroll_fill_r    <= scroll_fill_nxt;
    end
  end

  // Front end: accept and classify each input word.
  logic           cmd_full, cmd_empty, cmd_wr, cmd_pop, engine_busy;
  tccs_pkg::cmd_t cmd_in_word, cmd_head;
  logic [CMD_W-1:0] cmd_head_bits;

  tccs_front #(
    .ROWS (ROWS)
  ) u_front (
    .push          (push),
    .full          (full),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_row_count  (in_row_count),
    .in_fill_entry (in_fill_entry),
    .in_cell_index (in_cell_index),
    .queue_full    (cmd_full),
    .engine_busy   (engine_busy),
    .queue_wr      (cmd_wr),
    .queue_word    (cmd_in_word)
  );

  // Short command queue that decouples the front end from the engine.
  tccs_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in_word),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head_bits),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  assign cmd_head = tccs_pkg::cmd_t'(cmd_head_bits);

  // Back end: cursor, cell store and sweep sequencer.
  logic              res_valid, res_full;
  tccs_pkg::result_t res_word, res_head;
  logic [RES_W-1:0]  res_head_bits;

  tccs_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_attribute (text_attribute_r),
    .scroll_fill    (scroll_fill_r),
    .cmd_empty      (cmd_empty),
    .cmd_word       (cmd_head),
    .cmd_pop        (cmd_pop),
    .res_valid      (res_valid),
    .res_ready      (!res_full),
    .res_word       (res_word),
    .busy           (engine_busy)
  );

  // Result queue: the oldest word sits on the out_ ports while empty is low.
  tccs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res_word),
    .rd_en   (pop),
    .rd_data (res_head_bits),
    .full    (res_full),
    .empty   (empty)
  );

  assign res_head       = tccs_pkg::result_t'(res_head_bits);
  assign out_cursor_row = res_head.cursor_row;
  assign out_cursor_col = res_head.cursor_col;
  assign out_cursor_pos = res_head.cursor_pos;
  assign out_cell_data  = res_head.cell_data;

endmodule
